// ===== src/spsr_pkg.sv =====
`timescale 1ns / 1ps
// spsr_pkg: shared types, codes and constants of the servo pwm slew ramp unit
// no dependencies; imported by every module of the block

package spsr_pkg;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_TARGET  = 2'd1,
    KIND_CURRENT = 2'd2
  } kind_e;

  localparam logic [1:0] CFG_STEP_DELAY = 2'd0;
  localparam logic [1:0] CFG_PWM_PERIOD = 2'd1;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned DELAY_W     = 10;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned TIMER_W     = 20;
  localparam int unsigned ANG_W       = 8;
  localparam int unsigned PULSE_W     = 12;

  localparam logic [DELAY_W-1:0]  STEP_DELAY_RST = 10'd10;
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 16'd19999;
  localparam logic [ANG_W-1:0]    TARGET_RST     = 8'd90;

  // angle*100/9 == (angle*100*7282) >> 16 for every 8-bit angle
  localparam logic [27:0]         PULSE_RECIP = 28'd728200;
  localparam logic [PULSE_W-1:0]  PULSE_BASE  = 12'd500;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] angle;
  } in_word_t;

  typedef struct packed {
    logic               pwm_level;
    logic [ANG_W-1:0]   current_angle_out;
    logic [PULSE_W-1:0] pulse_width;
    logic               moving;
  } out_word_t;

  function automatic logic [PULSE_W-1:0] pulse_of(logic [ANG_W-1:0] ang);
    logic [27:0] prod;
    prod = 28'(ang) * PULSE_RECIP;
    return prod[27:16] + PULSE_BASE;
  endfunction

endpackage

// ===== src/servo_pwm_slew_ramp_unit.sv =====
`timescale 1ns / 1ps
// servo_pwm_slew_ramp_unit: top level of the rc servo pwm driver with angle ramp
// depends on spsr_pkg, spsr_core and spsr_outbuf
//
// input words are one-microsecond ticks, set-target or set-current commands;
// every accepted word gives exactly one output word with the pwm pin level,
// present angle, pulse width and moving flag after that word
// an accepted word sits in the input register; its state update and result are
// computed there and land in the result register, or in the skid stage while
// the result register is held, from which the result is offered
// throughput: one word per cycle while in_ready_o is high; the state update of
// one word fits between the input register and the result register
// a skid stage behind the result register keeps the input open while one
// result waits; when the receiver stalls long enough both fill and in_ready_o
// drops until a result is taken
// config writes (step delay, pwm period minus one) take effect at once; the user
// must make them while the unit is idle, the block itself does not enforce it
// reset: angle 0, target 90, period counter and step timer 0, step delay 10 ms,
// period 19999; both channels empty

module servo_pwm_slew_ramp_unit import spsr_pkg::*; #(
  parameter int unsigned TICKS_PER_MS = 1000,
  parameter int unsigned ANGLE_LIMIT  = 180
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic      space;
  logic      res_valid;
  out_word_t res_data;

  spsr_core #(
    .TICKS_PER_MS(TICKS_PER_MS),
    .ANGLE_LIMIT (ANGLE_LIMIT)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .space_i    (space),
    .res_valid_o(res_valid),
    .res_data_o (res_data)
  );

  spsr_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res_data),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== src/spsr_core.sv =====
`timescale 1ns / 1ps
// spsr_core: input register, angle ramp state, pwm counter and config registers
// depends on spsr_pkg

module spsr_core import spsr_pkg::*; #(
  parameter int unsigned TICKS_PER_MS = 1000,
  parameter int unsigned ANGLE_LIMIT  = 180
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  space_i,
  output logic                  res_valid_o,
  output out_word_t             res_data_o
);

  localparam int unsigned TICK_W  = $clog2(TICKS_PER_MS + 1);
  localparam int unsigned PROD_W  = (DELAY_W + TICK_W > TIMER_W + 1) ?
                                    DELAY_W + TICK_W : TIMER_W + 1;
  localparam longint unsigned TIMER_MAX = (64'd1 << TIMER_W) - 64'd1;
  localparam longint unsigned RST_PROD  = 64'(STEP_DELAY_RST) * 64'(TICKS_PER_MS) - 64'd1;
  localparam logic [TIMER_W-1:0] WAIT_RST = (RST_PROD > TIMER_MAX) ?
                                            TIMER_W'(TIMER_MAX) : TIMER_W'(RST_PROD);
  localparam logic [ANG_W-1:0] LIMIT = ANG_W'(ANGLE_LIMIT);

  logic                s_valid_q;
  in_word_t            s_item_q;
  logic                adv;

  logic [TIMER_W-1:0]  wait_q;
  logic [PERIOD_W-1:0] period_q;
  logic [ANG_W-1:0]    cur_q, cur_d;
  logic [ANG_W-1:0]    tgt_q, tgt_d;
  logic [PERIOD_W-1:0] cnt_q, cnt_d;
  logic [TIMER_W-1:0]  timer_q, timer_d;

  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   prod_m1;
  logic [TIMER_W-1:0]  wait_new;
  logic [ANG_W-1:0]    clamped;
  logic [PULSE_W-1:0]  pw;

  assign adv        = s_valid_q && space_i;
  assign in_ready_o = !s_valid_q || space_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s_valid_q <= 1'b1;
    end else if (adv) begin
      s_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s_item_q <= in_data_i;
    end
  end

  // step wait in ticks minus one, saturated to the timer width
  always_comb begin
    prod     = PROD_W'(cfg_data_i[DELAY_W-1:0]) * PROD_W'(TICKS_PER_MS);
    prod_m1  = prod - PROD_W'(1);
    wait_new = (prod_m1 > PROD_W'(TIMER_MAX)) ? TIMER_W'(TIMER_MAX) : prod_m1[TIMER_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q   <= WAIT_RST;
      period_q <= PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STEP_DELAY: begin
          if (cfg_data_i[DELAY_W-1:0] != '0) begin
            wait_q <= wait_new;
          end
        end
        CFG_PWM_PERIOD: begin
          period_q <= cfg_data_i[PERIOD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (s_item_q.angle[15]) begin
      clamped = '0;
    end else if (s_item_q.angle > $signed({1'b0, 15'(ANGLE_LIMIT)})) begin
      clamped = LIMIT;
    end else begin
      clamped = s_item_q.angle[ANG_W-1:0];
    end
  end

  always_comb begin
    cur_d   = cur_q;
    tgt_d   = tgt_q;
    cnt_d   = cnt_q;
    timer_d = timer_q;
    case (s_item_q.kind)
      KIND_TICK: begin
        cnt_d = (cnt_q >= period_q) ? '0 : cnt_q + PERIOD_W'(1);
        if (cur_q != tgt_q) begin
          if (timer_q == '0) begin
            cur_d   = (cur_q < tgt_q) ? cur_q + ANG_W'(1) : cur_q - ANG_W'(1);
            timer_d = wait_q;
          end else begin
            timer_d = timer_q - TIMER_W'(1);
          end
        end
      end
      KIND_TARGET: begin
        tgt_d   = clamped;
        timer_d = '0;
      end
      KIND_CURRENT: begin
        cur_d = clamped;
      end
      default: begin
      end
    endcase
    pw = pulse_of(cur_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      tgt_q   <= TARGET_RST;
      cnt_q   <= '0;
      timer_q <= '0;
    end else if (adv) begin
      cur_q   <= cur_d;
      tgt_q   <= tgt_d;
      cnt_q   <= cnt_d;
      timer_q <= timer_d;
    end
  end

  assign res_valid_o                  = adv;
  assign res_data_o.pwm_level         = (cnt_d < PERIOD_W'(pw));
  assign res_data_o.current_angle_out = cur_d;
  assign res_data_o.pulse_width       = pw;
  assign res_data_o.moving            = (cur_d != tgt_d);

endmodule

// ===== src/spsr_outbuf.sv =====
`timescale 1ns / 1ps
// spsr_outbuf: result register with a skid stage for the output channel
// depends on spsr_pkg

module spsr_outbuf import spsr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_word_t push_data_i,
  output logic      space_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  logic      out_valid_q;
  out_word_t out_q;
  logic      skid_valid_q;
  out_word_t skid_q;
  logic      load;

  assign load    = !out_valid_q || out_ready_i;
  assign space_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= skid_valid_q ? skid_q : push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/spsr_checker.sv =====
`timescale 1ns / 1ps
// spsr_checker: port-level assertions for servo_pwm_slew_ramp_unit, with bind
// depends on spsr_pkg and servo_pwm_slew_ramp_unit

module spsr_checker import spsr_pkg::*; #(
  parameter int unsigned ANGLE_LIMIT = 180
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  // output word holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // pulse width always matches the reported angle
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.pulse_width == pulse_of(out_data_o.current_angle_out))
    else $error("pulse width does not match angle");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.current_angle_out <= ANG_W'(ANGLE_LIMIT))
    else $error("angle beyond limit");

  // no new result without an earlier accepted word or an earlier valid output
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2) || $past(out_valid_o, 2)
                           || $past(in_valid_i && in_ready_o, 3))
    else $error("result without accepted word");

endmodule

bind servo_pwm_slew_ramp_unit spsr_checker #(
  .ANGLE_LIMIT(ANGLE_LIMIT)
) u_spsr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
